>>> rtl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types for the task priority scheduler: item layouts, operation
// codes, table entry layout and the control group of the best-entry tracker.
// ----------------------------------------------------------------------------
package tps_pkg;

    // operation codes carried by a request item
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_EDIT   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_EXEC   = 2'd3
    } op_t;

    // request item
    typedef struct packed {
        op_t         operation;
        logic [15:0] user_id;
        logic [7:0]  task_id;
        logic [31:0] priority_req;
    } req_item_t;

    // response item
    typedef struct packed {
        logic        found;
        logic [15:0] exec_user;
    } rsp_item_t;

    // one task table entry
    typedef struct packed {
        logic        valid;
        logic [15:0] user;
        logic [31:0] prio;
    } entry_t;

    // control of the best-entry tracker
    typedef struct packed {
        logic start;
        logic sample;
    } best_ctl_t;

endpackage

>>> rtl/tps_table.sv
// ----------------------------------------------------------------------------
// tps_table
// Task table memory: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module tps_table #(
    parameter int TASKS = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(TASKS)-1:0] wr_addr,
    input  tps_pkg::entry_t          wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(TASKS)-1:0] rd_addr,
    output tps_pkg::entry_t          rd_data
);

    tps_pkg::entry_t mem [TASKS];
    tps_pkg::entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/tps_best.sv
// ----------------------------------------------------------------------------
// tps_best
// Best-entry tracker: one priority comparator applied to each entry read
// during a scan, keeping the index and user of the current winner.
// ----------------------------------------------------------------------------
module tps_best #(
    parameter int TASKS = 256
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tps_pkg::best_ctl_t       ctl,
    input  logic [$clog2(TASKS)-1:0] idx,
    input  tps_pkg::entry_t          entry,
    output logic                     have,
    output logic [$clog2(TASKS)-1:0] best_idx,
    output logic [15:0]              best_user
);

    localparam int IDX_W = $clog2(TASKS);

    logic              have_reg;
    logic              have_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [15:0]       user_reg;
    logic [15:0]       user_next;
    logic [31:0]       prio_reg;
    logic [31:0]       prio_next;
    logic              take;

    // later entry wins a tie, scan runs in ascending order
    always_comb
    begin
        take      = ctl.sample && entry.valid && (!have_reg || (entry.prio >= prio_reg));
        have_next = have_reg;
        idx_next  = idx_reg;
        user_next = user_reg;
        prio_next = prio_reg;
        if (ctl.start)
        begin
            have_next = 1'b0;
        end
        else if (take)
        begin
            have_next = 1'b1;
            idx_next  = idx;
            user_next = entry.user;
            prio_next = entry.prio;
        end
    end

    // control flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
        end
    end

    // winner payload
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        user_reg <= user_next;
        prio_reg <= prio_next;
    end

    assign have      = have_reg;
    assign best_idx  = idx_reg;
    assign best_user = user_reg;

endmodule

>>> rtl/task_priority_scheduler.sv
// ----------------------------------------------------------------------------
// task_priority_scheduler
// Indexed max-priority task table with add, edit, remove and execute-top.
// ----------------------------------------------------------------------------
// Add and remove write the table straight from idle; edit reads the entry,
// then writes it back. Execute scans all TASKS entries through the single
// read port of the table, one entry a cycle into one priority comparator,
// then passes the drain and emit states before the response item is loaded
// (later if the response register is still held by stall). After reset the
// block runs a clearing pass over all TASKS entries of the table, with
// req_stall high, before the first item is taken. Ties in priority go to
// the greater task id; an empty table gives found = 0 with exec_user = 0.
// Task ids at or above TASKS are ignored by add, edit and remove.
module task_priority_scheduler #(
    parameter int TASKS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  tps_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output tps_pkg::rsp_item_t rsp
);

    localparam int               IDX_W    = $clog2(TASKS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASKS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EDIT,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [IDX_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   cnt_next;
    logic [IDX_W-1:0]   edit_idx_reg;
    logic [IDX_W-1:0]   edit_idx_next;
    logic [31:0]        edit_prio_reg;
    logic [31:0]        edit_prio_next;
    logic               rd_vld_reg;
    logic               rd_vld_next;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [IDX_W-1:0]   rd_idx_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    tps_pkg::rsp_item_t rsp_reg;
    tps_pkg::rsp_item_t rsp_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    tps_pkg::entry_t    wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    tps_pkg::entry_t    rd_data;

    tps_pkg::best_ctl_t best_ctl;
    logic               have;
    logic [IDX_W-1:0]   best_idx;
    logic [15:0]        best_user;

    logic               in_range;
    logic [IDX_W-1:0]   req_idx;
    logic               rsp_free;

    // task table
    tps_table #(
        .TASKS (TASKS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // comparator and winner registers
    tps_best #(
        .TASKS (TASKS)
    ) u_best (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (best_ctl),
        .idx       (rd_idx_reg),
        .entry     (rd_data),
        .have      (have),
        .best_idx  (best_idx),
        .best_user (best_user)
    );

    // request decode helpers
    assign in_range = ({24'd0, req.task_id} < 32'(TASKS));
    assign req_idx  = IDX_W'(req.task_id);
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        edit_idx_next  = edit_idx_reg;
        edit_prio_next = edit_prio_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = cnt_reg;
        best_ctl       = '0;
        best_ctl.sample = rd_vld_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg;
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req.operation)
                        tps_pkg::OP_ADD:
                        begin
                            wr_en        = in_range;
                            wr_addr      = req_idx;
                            wr_data.valid = 1'b1;
                            wr_data.user  = req.user_id;
                            wr_data.prio  = req.priority_req;
                        end
                        tps_pkg::OP_EDIT:
                        begin
                            if (in_range)
                            begin
                                rd_en          = 1'b1;
                                rd_addr        = req_idx;
                                edit_idx_next  = req_idx;
                                edit_prio_next = req.priority_req;
                                state_next     = S_EDIT;
                            end
                        end
                        tps_pkg::OP_REMOVE:
                        begin
                            wr_en   = in_range;
                            wr_addr = req_idx;
                        end
                        tps_pkg::OP_EXEC:
                        begin
                            best_ctl.start = 1'b1;
                            cnt_next       = '0;
                            state_next     = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EDIT:
            begin
                // only a valid task takes the new priority
                wr_en         = rd_data.valid;
                wr_addr       = edit_idx_reg;
                wr_data.valid = 1'b1;
                wr_data.user  = rd_data.user;
                wr_data.prio  = edit_prio_reg;
                state_next    = S_IDLE;
            end
            S_SCAN:
            begin
                rd_en       = 1'b1;
                rd_addr     = cnt_reg;
                rd_vld_next = 1'b1;
                rd_idx_next = cnt_reg;
                cnt_next    = cnt_reg + IDX_W'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last entry is compared in this cycle
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.found     = have;
                    rsp_next.exec_user = have ? best_user : 16'd0;
                    wr_en              = have;
                    wr_addr            = best_idx;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            edit_idx_reg  <= '0;
            edit_prio_reg <= '0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            edit_idx_reg  <= edit_idx_next;
            edit_prio_reg <= edit_prio_next;
            rd_vld_reg    <= rd_vld_next;
            rd_idx_reg    <= rd_idx_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    // finishing a scan with a free response register loads an item
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && rsp_free) |=> rsp_valid)
        else $error("scan result not loaded into response register");

    // the scan walks the table one entry a cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && cnt_reg != LAST_IDX) |=>
            (state_reg == S_SCAN && cnt_reg == $past(cnt_reg) + IDX_W'(1)))
        else $error("scan counter skipped an entry");

    // an empty-table response carries no user
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.found) |-> (rsp.exec_user == 16'd0))
        else $error("empty response with non-zero user");
`endif

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks task_priority_scheduler against a behavioural copy of the task
// table: each accepted request updates the copy, each execute queues the
// response it should give, and every response from the block is compared
// with the oldest one queued. Directed requests cover the edges, then a
// long random run with idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TASKS        = 256;
    localparam int NO_TASK      = -1;
    localparam int RANDOM_ITEMS = 1025;
    localparam int SETTLE       = TASKS + 16;
    localparam int LIMIT        = 1500000;

    // copy of the task table and the queue of responses still owed
    class sched_scoreboard;
        bit                 live [TASKS];
        logic [15:0]        owner [TASKS];
        logic [31:0]        rank [TASKS];
        tps_pkg::rsp_item_t due_q [$];
        int                 errors;

        function new();
            errors = 0;
            foreach (live[i])
            begin
                live[i] = 1'b0;
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function int live_count();
            int n;
            n = 0;
            foreach (live[i])
            begin
                if (live[i])
                    n++;
            end
            return n;
        endfunction

        // random valid task id, or none when the table is empty
        function int any_live_id();
            int start;
            int idx;
            start = $urandom_range(TASKS - 1);
            for (int k = 0; k < TASKS; k++)
            begin
                idx = (start + k) % TASKS;
                if (live[idx])
                    return idx;
            end
            return NO_TASK;
        endfunction

        // apply an accepted request; execute owes one response
        function void note_request(tps_pkg::req_item_t r);
            int                 best;
            tps_pkg::rsp_item_t owed;
            case (r.operation)
                tps_pkg::OP_ADD:
                begin
                    owner[r.task_id] = r.user_id;
                    rank[r.task_id]  = r.priority_req;
                    live[r.task_id]  = 1'b1;
                end
                tps_pkg::OP_EDIT:
                begin
                    if (live[r.task_id])
                        rank[r.task_id] = r.priority_req;
                end
                tps_pkg::OP_REMOVE:
                begin
                    live[r.task_id] = 1'b0;
                end
                default:
                begin
                    // ascending scan, >= hands a tie to the greater id
                    best = NO_TASK;
                    for (int i = 0; i < TASKS; i++)
                    begin
                        if (live[i] && (best == NO_TASK || rank[i] >= rank[best]))
                            best = i;
                    end
                    owed.found     = (best != NO_TASK);
                    owed.exec_user = '0;
                    if (best != NO_TASK)
                    begin
                        owed.exec_user = owner[best];
                        live[best]     = 1'b0;
                    end
                    due_q.push_back(owed);
                end
            endcase
        endfunction

        function void check_response(tps_pkg::rsp_item_t got);
            tps_pkg::rsp_item_t owed;
            if (due_q.size() == 0)
            begin
                $error("unexpected response: found %0d, exec_user %h",
                       got.found, got.exec_user);
                errors++;
                return;
            end
            owed = due_q.pop_front();
            if (got.found !== owed.found)
            begin
                $error("found: expected %0d, actual %0d", owed.found, got.found);
                errors++;
            end
            if (got.exec_user !== owed.exec_user)
            begin
                $error("exec_user: expected %h, actual %h",
                       owed.exec_user, got.exec_user);
                errors++;
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    tps_pkg::req_item_t req       = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    tps_pkg::rsp_item_t rsp;

    sched_scoreboard sb;
    bit              calm   = 1'b0;
    int              cycles = 0;

    task_priority_scheduler #(
        .TASKS(TASKS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver stalls at random except during the calm stretch
    always @(posedge clk)
    begin
        if (calm)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(99) < 33);
    end

    // response monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp);
    end

    function automatic tps_pkg::req_item_t make_item(tps_pkg::op_t op, logic [15:0] user,
                                                     logic [7:0] id, logic [31:0] prio);
        tps_pkg::req_item_t r;
        r.operation    = op;
        r.user_id      = user;
        r.task_id      = id;
        r.priority_req = prio;
        return r;
    endfunction

    // priorities: narrow range for ties, the extremes, or anything
    function automatic logic [31:0] rand_rank();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom_range(7);
            4:          return 32'h0000_0000;
            5:          return 32'hffff_ffff;
            default:    return $urandom;
        endcase
    endfunction

    // ids: half in a small corner so overwrites happen often
    function automatic logic [7:0] rand_slot();
        if ($urandom_range(1))
            return 8'($urandom_range(15));
        return 8'($urandom_range(TASKS - 1));
    endfunction

    // offer one item, with a random gap first, and hold it until taken
    task automatic send_request(input tps_pkg::req_item_t item);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(99) < 33)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(item);
    endtask

    task automatic send_exec();
        send_request(make_item(tps_pkg::OP_EXEC, 16'($urandom), 8'($urandom), $urandom));
    endtask

    // hold the sender off until every owed response is back
    task automatic wait_for_results();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // stimulus
    initial
    begin
        int           counted;
        int           roll;
        int           id;
        int           burst;
        bit           drained;
        tps_pkg::op_t noise_op;
        logic [7:0]   noise_id;

        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, extremes, tie to the greater id
        send_exec();
        send_request(make_item(tps_pkg::OP_ADD, 16'h0000, 8'd0, 32'h0000_0000));
        send_request(make_item(tps_pkg::OP_ADD, 16'hffff, 8'd255, 32'hffff_ffff));
        send_request(make_item(tps_pkg::OP_ADD, 16'h1234, 8'd7, 32'hffff_ffff));
        // edit and remove of absent tasks are ignored
        send_request(make_item(tps_pkg::OP_EDIT, 16'hffff, 8'd9, 32'hffff_ffff));
        send_request(make_item(tps_pkg::OP_REMOVE, 16'hffff, 8'd10, 32'hffff_ffff));
        send_exec();
        send_exec();
        // overwrite of an existing task, then an edit that lifts it
        send_request(make_item(tps_pkg::OP_ADD, 16'habcd, 8'd0, 32'd5));
        send_request(make_item(tps_pkg::OP_ADD, 16'h5555, 8'd3, 32'd5));
        send_request(make_item(tps_pkg::OP_EDIT, 16'h0000, 8'd0, 32'd6));
        send_exec();
        send_request(make_item(tps_pkg::OP_REMOVE, 16'h0000, 8'd3, 32'd0));
        send_exec();
        // edit down across the sign bit
        send_request(make_item(tps_pkg::OP_ADD, 16'haaaa, 8'd128, 32'h8000_0000));
        send_request(make_item(tps_pkg::OP_ADD, 16'h5555, 8'd127, 32'h7fff_ffff));
        send_request(make_item(tps_pkg::OP_EDIT, 16'hffff, 8'd128, 32'h0000_0000));
        send_exec();
        send_exec();
        send_exec();
        // edit after remove is ignored
        send_request(make_item(tps_pkg::OP_ADD, 16'h0f0f, 8'd200, 32'd9));
        send_request(make_item(tps_pkg::OP_REMOVE, 16'h0000, 8'd200, 32'd0));
        send_request(make_item(tps_pkg::OP_EDIT, 16'h0000, 8'd200, 32'hffff_ffff));
        send_exec();
        wait_for_results();

        // random run
        counted = 0;
        drained = 1'b0;
        while (counted < RANDOM_ITEMS)
        begin
            calm = (counted >= 400 && counted < 600);
            if (!drained && counted >= 700)
            begin
                wait_for_results();
                drained = 1'b1;
            end
            roll = $urandom_range(99);
            if (roll < 1)
            begin
                // empty the table and one more
                burst = sb.live_count() + 1;
                repeat (burst) send_exec();
                counted += burst;
            end
            else if (roll < 38)
            begin
                send_request(make_item(tps_pkg::OP_ADD, 16'($urandom), rand_slot(),
                                       rand_rank()));
                counted++;
            end
            else if (roll < 70)
            begin
                id = sb.any_live_id();
                if (id == NO_TASK)
                    send_exec();
                else if (roll < 58)
                    send_request(make_item(tps_pkg::OP_EDIT, 16'($urandom), 8'(id),
                                           rand_rank()));
                else
                    send_request(make_item(tps_pkg::OP_REMOVE, 16'($urandom), 8'(id),
                                           $urandom));
                counted++;
            end
            else if (roll < 93)
            begin
                send_exec();
                counted++;
            end
            else
            begin
                // edit or remove of any id, often absent
                noise_op = $urandom_range(1) ? tps_pkg::OP_EDIT : tps_pkg::OP_REMOVE;
                noise_id = 8'($urandom_range(TASKS - 1));
                send_request(make_item(noise_op, 16'($urandom), noise_id, rand_rank()));
                counted++;
            end
        end
        calm = 1'b0;

        wait_for_results();
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
